FILE: rtl/timestamp_ring_latency_monitor_top_assert.svh
// Assertion macros for the timestamp ring latency monitor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TIMESTAMP_RING_LATENCY_MONITOR_TOP_ASSERT_SVH
`define TIMESTAMP_RING_LATENCY_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSRLM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle assertion failed.");

// Next-cycle implication, disabled during reset.
`define TSRLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle assertion failed.");

`endif

FILE: rtl/tsrlm_pkg.sv
// Package for the timestamp ring latency monitor: sizes, status codes and
// the event and result structures. Depends on nothing.
package tsrlm_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int CNT_W      = 8;

  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MEASURED = 3'd4;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] time_now_us;
  } event_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   delay_us;
    logic                over_threshold;
    logic [CNT_W-1:0]    pending_count;
  } result_t;

endpackage

FILE: rtl/timestamp_ring_latency_monitor_top.sv
// Top level of the timestamp ring latency monitor.
// Depends on tsrlm_pkg, tsrlm_input_stage, tsrlm_ring_ctrl and tsrlm_result_stage.
//
// Each input transaction carries a command (push or pop) and the current
// microsecond time. A push stores the time in a ring of sixteen slots that
// holds at most fifteen entries; a pop takes the oldest entry and reports
// the elapsed time modulo 2^32, flagged when it reaches the warning threshold.
// A push into a full ring sets a sticky stopped condition, after which every
// transaction is reported as ignored until reset.
// Every input transaction produces exactly one result transaction. The input
// is registered, the decision and subtraction are combinational, and the
// result is registered; out_valid rises after both registers are passed.
// One transaction per cycle is sustained while out_ready is high; the
// subtract-compare against the registered oldest timestamp sets that figure.
// The threshold is written through the cfg channel, which is always ready,
// and resets to all ones. Reset empties the ring and clears stopped.
// When the receiver holds out_ready low the result register keeps its
// transaction, one more may wait in the input register, and in_ready falls.
module timestamp_ring_latency_monitor_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [tsrlm_pkg::TIME_W-1:0]   in_time_now_us,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tsrlm_pkg::STATUS_W-1:0] out_status,
  output logic [tsrlm_pkg::TIME_W-1:0]   out_delay_us,
  output logic                           out_over_threshold,
  output logic [tsrlm_pkg::CNT_W-1:0]    out_pending_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tsrlm_pkg::TIME_W-1:0]   cfg_warn_threshold_us
);

  tsrlm_pkg::event_t            in_event;
  tsrlm_pkg::event_t            ev;
  tsrlm_pkg::result_t           result;
  tsrlm_pkg::result_t           out_result;
  logic                         ev_valid;
  logic                         advance;
  logic [tsrlm_pkg::TIME_W-1:0] warn_threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_threshold_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      warn_threshold_r <= cfg_warn_threshold_us;
    end
  end

  assign in_event.command     = in_command;
  assign in_event.time_now_us = in_time_now_us;

  tsrlm_input_stage u_input_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_event (in_event),
    .advance  (advance),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  tsrlm_ring_ctrl u_ring_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .ev_valid       (ev_valid),
    .ev             (ev),
    .advance        (advance),
    .warn_threshold (warn_threshold_r),
    .result         (result)
  );

  tsrlm_result_stage u_result_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_valid   (ev_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_status         = out_result.status;
  assign out_delay_us       = out_result.delay_us;
  assign out_over_threshold = out_result.over_threshold;
  assign out_pending_count  = out_result.pending_count;

endmodule

FILE: rtl/tsrlm_input_stage.sv
// Input register of the timestamp ring latency monitor.
// Depends on tsrlm_pkg for the event structure.
module tsrlm_input_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tsrlm_pkg::event_t      in_event,
  input  logic                   advance,
  output logic                   ev_valid,
  output tsrlm_pkg::event_t      ev
);

  logic              ev_valid_r;
  logic              ev_valid_nxt;
  tsrlm_pkg::event_t ev_r;

  assign in_ready     = !ev_valid_r || advance;
  assign ev_valid_nxt = in_ready ? in_valid : ev_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else begin
      ev_valid_r <= ev_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_r <= in_event;
    end
  end

  assign ev_valid = ev_valid_r;
  assign ev       = ev_r;

endmodule

FILE: rtl/tsrlm_ring_ctrl.sv
// Ring state, timestamp store and per-transaction decision logic.
// Depends on tsrlm_pkg and the assertion macro header.
`include "timestamp_ring_latency_monitor_top_assert.svh"

module tsrlm_ring_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ev_valid,
  input  tsrlm_pkg::event_t            ev,
  input  logic                         advance,
  input  logic [tsrlm_pkg::TIME_W-1:0] warn_threshold,
  output tsrlm_pkg::result_t           result
);

  logic                          take;
  logic [tsrlm_pkg::IDX_W-1:0]   head_r;
  logic [tsrlm_pkg::IDX_W-1:0]   head_nxt;
  logic [tsrlm_pkg::IDX_W-1:0]   tail_r;
  logic [tsrlm_pkg::IDX_W-1:0]   tail_nxt;
  logic                          stopped_r;
  logic                          stopped_nxt;
  logic [tsrlm_pkg::IDX_W-1:0]   pend_now;
  logic [tsrlm_pkg::IDX_W-1:0]   rd_idx;
  logic [tsrlm_pkg::TIME_W-1:0]  tail_stamp_r;
  logic [tsrlm_pkg::TIME_W-1:0]  diff;
  logic                          store_en;
  logic [tsrlm_pkg::TIME_W-1:0]  stamp_mem [tsrlm_pkg::RING_DEPTH];

  function automatic logic [tsrlm_pkg::IDX_W-1:0] next_idx(
    input logic [tsrlm_pkg::IDX_W-1:0] idx
  );
    logic [tsrlm_pkg::IDX_W-1:0] res;
    if (idx == tsrlm_pkg::IDX_W'(tsrlm_pkg::RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + tsrlm_pkg::IDX_W'(1);
    end
    return res;
  endfunction

  function automatic logic [tsrlm_pkg::IDX_W-1:0] ring_count(
    input logic [tsrlm_pkg::IDX_W-1:0] h,
    input logic [tsrlm_pkg::IDX_W-1:0] t
  );
    logic [tsrlm_pkg::IDX_W:0] s;
    s = {1'b0, h} - {1'b0, t};
    if (h < t) begin
      s = s + (tsrlm_pkg::IDX_W + 1)'(tsrlm_pkg::RING_DEPTH);
    end
    return s[tsrlm_pkg::IDX_W-1:0];
  endfunction

  // The oldest timestamp is kept in a register that follows the tail.
  assign take     = ev_valid && advance;
  assign pend_now = ring_count(head_r, tail_r);
  assign rd_idx   = take ? tail_nxt : tail_r;
  assign diff     = ev.time_now_us - tail_stamp_r;

  always_comb begin
    head_nxt              = head_r;
    tail_nxt              = tail_r;
    stopped_nxt           = stopped_r;
    store_en              = 1'b0;
    result.status         = tsrlm_pkg::ST_IGNORED;
    result.delay_us       = '0;
    result.over_threshold = 1'b0;
    priority if (stopped_r) begin
      result.status = tsrlm_pkg::ST_IGNORED;
    end else if (ev.command == tsrlm_pkg::CMD_PUSH) begin
      if (pend_now == tsrlm_pkg::IDX_W'(tsrlm_pkg::RING_DEPTH - 1)) begin
        stopped_nxt   = 1'b1;
        result.status = tsrlm_pkg::ST_DROPPED;
      end else begin
        store_en      = 1'b1;
        head_nxt      = next_idx(head_r);
        result.status = tsrlm_pkg::ST_STORED;
      end
    end else if (tail_r == head_r) begin
      result.status = tsrlm_pkg::ST_EMPTY;
    end else begin
      tail_nxt              = next_idx(tail_r);
      result.status         = tsrlm_pkg::ST_MEASURED;
      result.delay_us       = diff;
      result.over_threshold = (diff >= warn_threshold);
    end
    result.pending_count = tsrlm_pkg::CNT_W'(ring_count(head_nxt, tail_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      stopped_r <= 1'b0;
    end else if (take) begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // A push into an empty ring writes the slot that the tail points at.
  always_ff @(posedge clk) begin
    if (take && store_en) begin
      stamp_mem[head_r] <= ev.time_now_us;
    end
    if (take && store_en && (head_r == tail_r)) begin
      tail_stamp_r <= ev.time_now_us;
    end else begin
      tail_stamp_r <= stamp_mem[rd_idx];
    end
  end

  `TSRLM_ASSERT_NEXT(a_stopped_sticky, clk, rst_n, stopped_r, stopped_r)
  `TSRLM_ASSERT_NEXT(a_stopped_freezes, clk, rst_n, stopped_r && take,
                     $stable(head_r) && $stable(tail_r))
  `TSRLM_ASSERT_NEXT(a_full_push_stops, clk, rst_n,
                     take && !stopped_r && ev.command == tsrlm_pkg::CMD_PUSH &&
                     pend_now == tsrlm_pkg::IDX_W'(tsrlm_pkg::RING_DEPTH - 1),
                     stopped_r && $stable(head_r))

endmodule

FILE: rtl/tsrlm_result_stage.sv
// Result register of the timestamp ring latency monitor.
// Depends on tsrlm_pkg for the result structure.
module tsrlm_result_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ev_valid,
  input  tsrlm_pkg::result_t  result,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output tsrlm_pkg::result_t  out_result
);

  logic               out_valid_r;
  logic               out_valid_nxt;
  tsrlm_pkg::result_t result_r;

  assign advance       = !out_valid_r || out_ready;
  assign out_valid_nxt = advance ? ev_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ev_valid) begin
      result_r <= result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for timestamp_ring_latency_monitor_top: directed push/pop probes,
// then phased random traffic checked against a bench ring predictor, then a full-ring stop.
// Depends on tsrlm_pkg and the monitor RTL; needs no files or arguments.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tsrlm_pkg::*;

  typedef struct {
    logic              command;
    logic [TIME_W-1:0] stamp;
    bit                pinned;
    result_t           want;
  } probe_t;

  localparam int PHASES        = 6;
  localparam int PHASE_EVENTS  = 90;
  localparam int TAIL_EVENTS   = 10;
  localparam int SETTLE_CYCLES = 4;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_command;
  logic [TIME_W-1:0]   in_time_now_us;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [TIME_W-1:0]   out_delay_us;
  logic                out_over_threshold;
  logic [CNT_W-1:0]    out_pending_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [TIME_W-1:0]   cfg_warn_threshold_us;

  logic [TIME_W-1:0] stamp_ring [RING_DEPTH];
  int                wr_slot;
  int                rd_slot;
  bit                halted;
  logic [TIME_W-1:0] warn_level;

  result_t           expected_results [$];
  int                errors;
  bit                tx_burst;
  bit                rx_burst;
  logic [TIME_W-1:0] clock_us;
  int                push_bias;
  int                bias_choices [3] = '{25, 55, 85};

  // The opening probes run with the threshold at its reset value of all ones.
  probe_t open_probes [15] = '{
    '{CMD_POP,  32'h0000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 1'b0, 8'd0}},
    '{CMD_PUSH, 32'hFFFF_FFFF, 1'b1, '{ST_STORED,   32'h0000_0000, 1'b0, 8'd1}},
    '{CMD_POP,  32'hFFFF_FFFE, 1'b1, '{ST_MEASURED, 32'hFFFF_FFFF, 1'b1, 8'd0}},
    '{CMD_PUSH, 32'h0000_0000, 1'b1, '{ST_STORED,   32'h0000_0000, 1'b0, 8'd1}},
    '{CMD_POP,  32'h0000_0000, 1'b1, '{ST_MEASURED, 32'h0000_0000, 1'b0, 8'd0}},
    '{CMD_PUSH, 32'hFFFF_FFF0, 1'b1, '{ST_STORED,   32'h0000_0000, 1'b0, 8'd1}},
    '{CMD_POP,  32'h0000_0010, 1'b1, '{ST_MEASURED, 32'h0000_0020, 1'b0, 8'd0}},
    '{CMD_POP,  32'h0000_0005, 1'b1, '{ST_EMPTY,    32'h0000_0000, 1'b0, 8'd0}},
    '{CMD_PUSH, 32'h1234_5678, 1'b0, '0},
    '{CMD_PUSH, 32'h89AB_CDEF, 1'b0, '0},
    '{CMD_PUSH, 32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_POP,  32'h5555_5555, 1'b0, '0},
    '{CMD_POP,  32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_POP,  32'h0000_0000, 1'b0, '0},
    '{CMD_POP,  32'h0000_0001, 1'b0, '0}
  };

  // These follow a fill to fifteen entries, so the first push overflows the ring.
  probe_t stop_probes [4] = '{
    '{CMD_PUSH, 32'h0000_0000, 1'b1, '{ST_DROPPED, 32'h0000_0000, 1'b0, 8'd15}},
    '{CMD_POP,  32'hFFFF_FFFF, 1'b1, '{ST_IGNORED, 32'h0000_0000, 1'b0, 8'd15}},
    '{CMD_PUSH, 32'hFFFF_FFFF, 1'b1, '{ST_IGNORED, 32'h0000_0000, 1'b0, 8'd15}},
    '{CMD_POP,  32'h0000_0000, 1'b1, '{ST_IGNORED, 32'h0000_0000, 1'b0, 8'd15}}
  };

  timestamp_ring_latency_monitor_top u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_time_now_us        (in_time_now_us),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_delay_us          (out_delay_us),
    .out_over_threshold    (out_over_threshold),
    .out_pending_count     (out_pending_count),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_warn_threshold_us (cfg_warn_threshold_us)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int ring_held();
    return (wr_slot + RING_DEPTH - rd_slot) % RING_DEPTH;
  endfunction

  function automatic result_t predict_event(logic cmd, logic [TIME_W-1:0] now_us);
    result_t r;
    r = '0;
    if (halted) begin
      r.status = ST_IGNORED;
    end else if (cmd == CMD_PUSH) begin
      if (ring_held() >= RING_DEPTH - 1) begin
        halted   = 1'b1;
        r.status = ST_DROPPED;
      end else begin
        stamp_ring[wr_slot] = now_us;
        wr_slot             = (wr_slot + 1) % RING_DEPTH;
        r.status            = ST_STORED;
      end
    end else if (rd_slot == wr_slot) begin
      r.status = ST_EMPTY;
    end else begin
      r.delay_us       = now_us - stamp_ring[rd_slot];
      rd_slot          = (rd_slot + 1) % RING_DEPTH;
      r.over_threshold = (r.delay_us >= warn_level);
      r.status         = ST_MEASURED;
    end
    r.pending_count = CNT_W'(ring_held());
    return r;
  endfunction

  task automatic send_event(logic cmd, logic [TIME_W-1:0] now_us, bit pinned, result_t want);
    int      gap;
    result_t predicted;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_time_now_us <= now_us;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = predict_event(cmd, now_us);
    expected_results.push_back(pinned ? want : predicted);
  endtask

  task automatic send_random_event();
    logic              cmd;
    logic [TIME_W-1:0] now_us;
    if (ring_held() >= RING_DEPTH - 1) begin
      cmd = CMD_POP;
    end else begin
      cmd = ($urandom_range(0, 99) < push_bias) ? CMD_PUSH : CMD_POP;
    end
    clock_us += ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 60);
    now_us = ($urandom_range(0, 19) == 0) ? $urandom() : clock_us;
    send_event(cmd, now_us, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(logic [TIME_W-1:0] level);
    cfg_valid             <= 1'b1;
    cfg_warn_threshold_us <= level;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    warn_level = level;
  endtask

  task automatic report_field(string name, logic [TIME_W-1:0] exp_val,
                              logic [TIME_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  initial begin : result_checker
    int      stall;
    result_t got;
    result_t want;
    out_ready = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.status         = out_status;
      got.delay_us       = out_delay_us;
      got.over_threshold = out_over_threshold;
      got.pending_count  = out_pending_count;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual status %0d",
                 $time, got.status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        report_field("status", want.status, got.status);
        report_field("delay_us", want.delay_us, got.delay_us);
        report_field("over_threshold", want.over_threshold, got.over_threshold);
        report_field("pending_count", want.pending_count, got.pending_count);
      end
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0] level;
    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_command            = CMD_PUSH;
    in_time_now_us        = '0;
    cfg_valid             = 1'b0;
    cfg_warn_threshold_us = '0;
    errors                = 0;
    wr_slot               = 0;
    rd_slot               = 0;
    halted                = 1'b0;
    warn_level            = '1;
    clock_us              = $urandom();
    push_bias             = 50;
    tx_burst              = 1'b0;
    rx_burst              = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (open_probes[i]) begin
      send_event(open_probes[i].command, open_probes[i].stamp,
                 open_probes[i].pinned, open_probes[i].want);
    end
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       level = '0;
        1:       level = $urandom_range(1, 40);
        2:       level = $urandom();
        3:       level = '1;
        4:       level = 1;
        default: level = $urandom_range(20, 300);
      endcase
      set_threshold(level);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        if (n % 20 == 0) begin
          push_bias = bias_choices[$urandom_range(0, 2)];
        end
        send_random_event();
      end
      drain_results();
    end

    tx_burst = 1'b0;
    rx_burst = 1'b0;
    while (ring_held() < RING_DEPTH - 1) begin
      send_event(CMD_PUSH, $urandom(), 1'b0, '0);
    end
    foreach (stop_probes[i]) begin
      send_event(stop_probes[i].command, stop_probes[i].stamp,
                 stop_probes[i].pinned, stop_probes[i].want);
    end
    repeat (TAIL_EVENTS) begin
      send_event(logic'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
    end
    drain_results();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
